/* rtl/fmb_pkg.sv */
// Shared types, codes and an arithmetic helper for the fragment modulate and blend unit.
`default_nettype none

package fmb_pkg;

   localparam int CFG_W       = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int DIM_W       = 13;
   localparam int CHAN_W      = 8;
   localparam int PROD_W      = 16;

   localparam logic [16:0] RND_BIAS = 17'd128;
   localparam logic [7:0]  CHAN_MAX = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LEFT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_TOP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_RIGHT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_BOTTOM  = 3'd5;

   localparam logic [CFG_W-1:0] CFG_FULL = 9'd256;

   typedef enum logic [1:0] {
      ACT_BLEND = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_DONE    = 2'd0,
      STS_SKIPPED = 2'd1,
      STS_CLIPPED = 2'd2,
      STS_READ    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_MOD,
      ST_BLEND,
      ST_FIN,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // rounded divide by 255 for values up to 255*255
   function automatic logic [7:0] rdiv255(input logic [15:0] v);
      logic [16:0] t;
      logic [16:0] u;
      t = {1'b0, v} + RND_BIAS;
      u = t + {8'd0, t[16:8]};
      return u[15:8];
   endfunction

endpackage

`default_nettype wire

/* rtl/fmb_req_if.sv */
// Request channel: valid/ready handshake carrying one fragment, read or clear request.
`default_nettype none

interface fmb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  pos_x;
   logic [7:0]  pos_y;
   logic [31:0] texel_rgba;
   logic        has_texel;
   logic [31:0] vertex_rgba;

   modport source (
      output valid, action, pos_x, pos_y, texel_rgba, has_texel, vertex_rgba,
      input  ready
   );
   modport sink (
      input  valid, action, pos_x, pos_y, texel_rgba, has_texel, vertex_rgba,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/fmb_rsp_if.sv */
// Response channel: valid/ready handshake carrying the resulting pixel and status.
`default_nettype none

interface fmb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_rgba;
   logic [1:0]  status;

   modport source (
      output valid, pixel_rgba, status,
      input  ready
   );
   modport sink (
      input  valid, pixel_rgba, status,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/fmb_store.sv */
// Frame store RAM: one write port, one read port, registered read data.
`default_nettype none

module fmb_store #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [31:0]       wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [31:0]       rdata
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/fragment_modulate_and_blend_core.sv */
// Fragment modulate and blend raster unit over an RGBA8888 frame store.
//
// req_if takes one request at a time: a fragment blend, a pixel read or a
// full-store clear. rsp_if returns exactly one response per request.
// Config registers (frame size, scissor) are written through csr_we /
// csr_index / csr_wdata while no request is in flight.
// States passed from request accept to response valid:
//   fragment that is blended            : READ, MOD, BLEND, FIN, DONE
//   fragment transparent or overwriting : READ, MOD, BLEND, DONE
//   read inside the frame               : READ, MOD, DONE
//   clipped fragment/read, unused code  : DONE
//   clear                               : CLEAR over every store word, DONE
// The frame store is swept one word per cycle on clear.
// A new request is accepted the cycle after the previous one's response
// enters the output register. After reset the unit sweeps every store
// word to zero with req_if.ready low; registers are writable during the
// sweep. A stalled response holds in the output register; the next
// request is taken and worked on meanwhile, and its response waits until
// the output register frees.
`default_nettype none

module fragment_modulate_and_blend_core #(
   parameter int FRAME_MAX_W = 256,
   parameter int FRAME_MAX_H = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   fmb_req_if.sink                             req_if,
   fmb_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [fmb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fmb_pkg::CFG_W-1:0]           csr_wdata
);
   import fmb_pkg::*;

   localparam int DEPTH  = FRAME_MAX_W * FRAME_MAX_H;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [DIM_W-1:0]  MAX_W     = DIM_W'(FRAME_MAX_W);
   localparam logic [DIM_W-1:0]  MAX_H     = DIM_W'(FRAME_MAX_H);

   state_type state_ff, state_in;

   logic [CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic [CFG_W-1:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;

   action_type        op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [31:0]       tex_ff, tex_in;
   logic [31:0]       vert_ff, vert_in;
   logic [3:0][PROD_W-1:0] prod_ff, prod_in;
   logic [3:0][CHAN_W-1:0] s_ff, s_in;
   logic [31:0]       dst_ff, dst_in;
   logic [3:0][PROD_W-1:0] sum_ff, sum_in;
   logic [31:0]       res_pix_ff, res_pix_in;
   status_type        res_status_ff, res_status_in;
   logic              res_we_ff, res_we_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_pix_ff, rsp_pix_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr;
   logic [31:0]       mem_wdata, mem_rdata;

   logic [CFG_W-1:0]  req_x9, req_y9;
   logic              req_in_frame, req_inside;
   logic [ADDR_W-1:0] req_addr;
   logic [CHAN_W-1:0] inv;
   logic [3:0][CHAN_W-1:0] blend_out;
   logic              out_free;

   // request decode
   assign req_x9 = {1'b0, req_if.pos_x};
   assign req_y9 = {1'b0, req_if.pos_y};
   assign req_in_frame = (req_x9 < frame_width_ff) && (req_y9 < frame_height_ff) &&
                         ({5'd0, req_if.pos_x} < MAX_W) && ({5'd0, req_if.pos_y} < MAX_H);
   assign req_inside = req_in_frame &&
                       (req_x9 >= clip_left_ff) && (req_x9 < clip_right_ff) &&
                       (req_y9 >= clip_top_ff) && (req_y9 < clip_bottom_ff);
   assign req_addr = ADDR_W'(ADDR_W'(req_if.pos_y) * ADDR_W'(FRAME_MAX_W)) +
                     ADDR_W'(req_if.pos_x);

   assign inv = CHAN_MAX - s_ff[3];
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         blend_out[k] = rdiv255(sum_ff[k]);
      end
      blend_out[3] = s_ff[3] + rdiv255(sum_ff[3]);
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      tex_in        = tex_ff;
      vert_in       = vert_ff;
      prod_in       = prod_ff;
      s_in          = s_ff;
      dst_in        = dst_ff;
      sum_in        = sum_ff;
      res_pix_in    = res_pix_ff;
      res_status_in = res_status_ff;
      res_we_in     = res_we_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_pix_in    = rsp_pix_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = res_pix_ff;
      req_if.ready  = 1'b0;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               clr_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               op_in         = action_type'(req_if.action);
               addr_in       = req_addr;
               tex_in        = req_if.has_texel ? req_if.texel_rgba : '1;
               vert_in       = req_if.vertex_rgba;
               res_pix_in    = '0;
               res_status_in = STS_CLIPPED;
               res_we_in     = 1'b0;
               unique case (action_type'(req_if.action))
                  ACT_BLEND: state_in = req_inside ? ST_READ : ST_DONE;
                  ACT_READ:  state_in = req_in_frame ? ST_READ : ST_DONE;
                  ACT_CLEAR: begin
                     res_status_in = STS_DONE;
                     state_in      = ST_CLEAR;
                  end
                  ACT_NONE: begin
                     res_status_in = STS_DONE;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            mem_re = 1'b1;
            for (int k = 0; k < 4; k++) begin
               prod_in[k] = PROD_W'(tex_ff[8*k +: 8]) * PROD_W'(vert_ff[8*k +: 8]);
            end
            state_in = ST_MOD;
         end
         ST_MOD: begin
            for (int k = 0; k < 4; k++) begin
               s_in[k] = rdiv255(prod_ff[k]);
            end
            dst_in = mem_rdata;
            if (op_ff == ACT_READ) begin
               res_pix_in    = mem_rdata;
               res_status_in = STS_READ;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (s_ff[3] == '0) begin
               res_pix_in    = dst_ff;
               res_status_in = STS_SKIPPED;
               state_in      = ST_DONE;
            end else if (s_ff[3] == CHAN_MAX) begin
               res_pix_in    = s_ff;
               res_status_in = STS_DONE;
               res_we_in     = 1'b1;
               state_in      = ST_DONE;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  sum_in[k] = PROD_W'(s_ff[k]) * PROD_W'(s_ff[3]) +
                              PROD_W'(dst_ff[8*k +: 8]) * PROD_W'(inv);
               end
               sum_in[3] = PROD_W'(dst_ff[31:24]) * PROD_W'(inv);
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            res_pix_in    = blend_out;
            res_status_in = STS_DONE;
            res_we_in     = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pix_in    = res_pix_ff;
               rsp_status_in = res_status_ff;
               mem_we        = res_we_ff;
               res_we_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         res_we_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         res_we_ff    <= res_we_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      tex_ff        <= tex_in;
      vert_ff       <= vert_in;
      prod_ff       <= prod_in;
      s_ff          <= s_in;
      dst_ff        <= dst_in;
      sum_ff        <= sum_in;
      res_pix_ff    <= res_pix_in;
      res_status_ff <= res_status_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_FULL;
         frame_height_ff <= CFG_FULL;
         clip_left_ff    <= '0;
         clip_top_ff     <= '0;
         clip_right_ff   <= CFG_FULL;
         clip_bottom_ff  <= CFG_FULL;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            CSR_CLIP_LEFT:    clip_left_ff    <= csr_wdata;
            CSR_CLIP_TOP:     clip_top_ff     <= csr_wdata;
            CSR_CLIP_RIGHT:   clip_right_ff   <= csr_wdata;
            CSR_CLIP_BOTTOM:  clip_bottom_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   fmb_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (addr_ff),
      .rdata (mem_rdata)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_rgba = rsp_pix_ff;
   assign rsp_if.status     = rsp_status_ff;

   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |-> !req_if.ready && !rsp_valid_ff)
      else $error("request or response during reset sweep");

   a_sweep_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT || state_ff == ST_CLEAR) && mem_we |-> mem_wdata == '0)
      else $error("nonzero write during store sweep");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("store written while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside completion state");

endmodule

`default_nettype wire

/* tb/tb_fragment_modulate_and_blend_core.sv */
// Self-checking testbench: fragment blend, read and clear requests against a frame store model.
`default_nettype none

module tb_fragment_modulate_and_blend_core;
   import fmb_pkg::*;

   localparam int IDLE_LIMIT  = 300000;
   localparam int STORE_WORDS = 65536;

   typedef struct {
      action_type action;
      bit [7:0]   x;
      bit [7:0]   y;
      bit [31:0]  texel;
      bit         has_texel;
      bit [31:0]  vertex;
   } fragment_req_type;

   typedef struct {
      bit [31:0]  pixel;
      status_type status;
   } pixel_result_type;

   class raster_scoreboard;
      bit [31:0]        pixels [STORE_WORDS];
      bit [8:0]         frame_w = 256;
      bit [8:0]         frame_h = 256;
      bit [8:0]         clip_l  = 0;
      bit [8:0]         clip_t  = 0;
      bit [8:0]         clip_r  = 256;
      bit [8:0]         clip_b  = 256;
      pixel_result_type pending_pixels [$];
      int               errors, written, skipped, clipped, reads, clears, unused;

      function void set_register(logic [CSR_INDEX_W-1:0] idx, bit [8:0] v);
         case (idx)
            CSR_FRAME_WIDTH:  frame_w = v;
            CSR_FRAME_HEIGHT: frame_h = v;
            CSR_CLIP_LEFT:    clip_l  = v;
            CSR_CLIP_TOP:     clip_t  = v;
            CSR_CLIP_RIGHT:   clip_r  = v;
            CSR_CLIP_BOTTOM:  clip_b  = v;
            default: ;
         endcase
      endfunction

      function int unsigned div255_round(int unsigned v);
         int unsigned t;
         t = v + 128;
         return (t + (t >> 8)) >> 8;
      endfunction

      function int unsigned prod(bit [7:0] a, bit [7:0] b);
         return 32'(a) * 32'(b);
      endfunction

      function bit in_frame(bit [7:0] x, bit [7:0] y);
         return x < frame_w && y < frame_h;
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function void apply_request(fragment_req_type r);
         bit [31:0]        tex;
         bit [31:0]        stored;
         bit [31:0]        result;
         bit [7:0]         src [4];
         bit [7:0]         inv;
         bit [15:0]        addr;
         pixel_result_type e;
         e.pixel  = '0;
         e.status = STS_DONE;
         result   = '0;
         addr     = {r.y, r.x};
         case (r.action)
            ACT_BLEND: begin
               if (!(in_frame(r.x, r.y) && r.x >= clip_l && r.x < clip_r &&
                     r.y >= clip_t && r.y < clip_b)) begin
                  e.status = STS_CLIPPED;
                  clipped++;
               end else begin
                  tex = r.has_texel ? r.texel : 32'hFFFF_FFFF;
                  for (int k = 0; k < 4; k++)
                     src[k] = 8'(div255_round(prod(tex[8*k +: 8], r.vertex[8*k +: 8])));
                  stored = pixels[addr];
                  if (src[3] == 8'd0) begin
                     e.pixel  = stored;
                     e.status = STS_SKIPPED;
                     skipped++;
                  end else begin
                     if (src[3] == CHAN_MAX) begin
                        result = {src[3], src[2], src[1], src[0]};
                     end else begin
                        inv = CHAN_MAX - src[3];
                        for (int k = 0; k < 3; k++)
                           result[8*k +: 8] = 8'(div255_round(prod(src[k], src[3]) +
                                                              prod(stored[8*k +: 8], inv)));
                        result[31:24] = src[3] + 8'(div255_round(prod(stored[31:24], inv)));
                     end
                     pixels[addr] = result;
                     e.pixel      = result;
                     written++;
                  end
               end
            end
            ACT_READ: begin
               if (in_frame(r.x, r.y)) begin
                  e.pixel  = pixels[addr];
                  e.status = STS_READ;
                  reads++;
               end else begin
                  e.status = STS_CLIPPED;
                  clipped++;
               end
            end
            ACT_CLEAR: begin
               foreach (pixels[i]) pixels[i] = '0;
               clears++;
            end
            default: unused++;
         endcase
         pending_pixels.push_back(e);
      endfunction

      function void check_pixel(logic [31:0] pix, logic [1:0] st);
         pixel_result_type e;
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, pixel %h status %0d", $time, pix, st);
            return;
         end
         e = pending_pixels.pop_front();
         if (pix !== e.pixel) begin
            errors++;
            $display("%0t: pixel mismatch, expected %h, actual %h", $time, e.pixel, pix);
         end
         if (st !== e.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, st);
         end
      endfunction

      function void finish_check();
         if (pending_pixels.size() != 0) begin
            errors += pending_pixels.size();
            $display("%0t: %0d responses never arrived", $time, pending_pixels.size());
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   fmb_req_if req_ch ();
   fmb_rsp_if rsp_ch ();

   fragment_modulate_and_blend_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   raster_scoreboard sb;
   int               idle_cycles = 0;
   int               settings    = 0;
   int               requests    = 0;
   int               clear_budget = 3;
   bit               tx_burst    = 0;
   bit               rx_burst    = 0;
   bit [7:0]         hot_x, hot_y;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (req_ch.valid && req_ch.ready) moved = 1'b1;
      if (rsp_ch.valid && rsp_ch.ready) begin
         moved = 1'b1;
         sb.check_pixel(rsp_ch.pixel_rgba, rsp_ch.status);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = rx_burst ? 0 : $urandom_range(0, 19);
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic write_config(input bit [8:0] w, h, l, t, r, b);
      bit [8:0]               vals [6];
      logic [CSR_INDEX_W-1:0] regs [6];
      vals = '{w, h, l, t, r, b};
      regs = '{CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_CLIP_LEFT,
               CSR_CLIP_TOP, CSR_CLIP_RIGHT, CSR_CLIP_BOTTOM};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         sb.set_register(regs[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings++;
   endtask

   task automatic random_config();
      int l, t;
      l = $urandom_range(0, 200);
      t = $urandom_range(0, 200);
      write_config(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)), 9'(l), 9'(t),
                   9'($urandom_range(l, 256)), 9'($urandom_range(t, 256)));
   endtask

   task automatic send_request(input fragment_req_type r, input bit eager);
      int gap;
      gap = (eager || tx_burst) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= r.action;
      req_ch.pos_x       <= r.x;
      req_ch.pos_y       <= r.y;
      req_ch.texel_rgba  <= r.texel;
      req_ch.has_texel   <= r.has_texel;
      req_ch.vertex_rgba <= r.vertex;
      do @(posedge clock); while (!req_ch.ready);
      sb.apply_request(r);
      requests++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic fragment_req_type make_req(action_type a, bit [7:0] x, bit [7:0] y,
                                                 bit [31:0] texel, bit has, bit [31:0] vert);
      fragment_req_type r;
      r.action    = a;
      r.x         = x;
      r.y         = y;
      r.texel     = texel;
      r.has_texel = has;
      r.vertex    = vert;
      return r;
   endfunction

   // alpha biased toward opaque and fully transparent so all blend paths get hit
   function automatic bit [31:0] random_color();
      int       pick;
      bit [7:0] alpha;
      pick  = $urandom_range(0, 7);
      alpha = (pick < 2) ? CHAN_MAX : (pick == 2) ? 8'd0 : 8'($urandom);
      return {alpha, 24'($urandom)};
   endfunction

   function automatic void retarget_hot();
      int lo_x, hi_x, lo_y, hi_y;
      lo_x = sb.clip_l;
      hi_x = ((sb.clip_r < sb.frame_w) ? sb.clip_r : sb.frame_w) - 1;
      lo_y = sb.clip_t;
      hi_y = ((sb.clip_b < sb.frame_h) ? sb.clip_b : sb.frame_h) - 1;
      hot_x = (hi_x >= lo_x && lo_x <= 255) ?
              8'($urandom_range(lo_x, (hi_x > 255) ? 255 : hi_x)) : 8'($urandom);
      hot_y = (hi_y >= lo_y && lo_y <= 255) ?
              8'($urandom_range(lo_y, (hi_y > 255) ? 255 : hi_y)) : 8'($urandom);
   endfunction

   function automatic fragment_req_type random_request();
      fragment_req_type r;
      int               pick;
      pick = $urandom_range(0, 99);
      if (clear_budget > 0 && $urandom_range(0, 399) == 0) begin
         r.action = ACT_CLEAR;
         clear_budget--;
      end else if (pick < 68) begin
         r.action = ACT_BLEND;
      end else if (pick < 92) begin
         r.action = ACT_READ;
      end else if (pick < 95) begin
         r.action = ACT_NONE;
      end else begin
         r.action = ACT_BLEND;
      end
      if ($urandom_range(0, 4) == 0) begin
         r.x = 8'($urandom);
         r.y = 8'($urandom);
      end else begin
         r.x = hot_x + 8'($urandom_range(0, 5));
         r.y = hot_y + 8'($urandom_range(0, 5));
      end
      r.texel     = random_color();
      r.has_texel = 1'($urandom_range(0, 1));
      r.vertex    = random_color();
      return r;
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) retarget_hot();
         if (i == count / 2 && $urandom_range(0, 1) == 1) drain();
         send_request(random_request(), 1'b0);
      end
      drain();
   endtask

   initial begin
      int e;
      sb                 = new();
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_FRAME_WIDTH;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_BLEND;
      req_ch.pos_x       <= '0;
      req_ch.pos_y       <= '0;
      req_ch.texel_rgba  <= '0;
      req_ch.has_texel   <= 1'b0;
      req_ch.vertex_rgba <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_config(256, 256, 0, 0, 256, 256);
      send_request(make_req(ACT_READ,  0,   0,   32'h0,         0, 32'h0), 1'b0);
      send_request(make_req(ACT_BLEND, 0,   0,   32'h0,         0, 32'hFFFF_FFFF), 1'b0);
      send_request(make_req(ACT_BLEND, 0,   0,   32'h00FF_FFFF, 1, 32'hFFFF_FFFF), 1'b0);
      send_request(make_req(ACT_BLEND, 0,   0,   32'h8010_2030, 1, 32'hFFFF_FFFF), 1'b0);
      send_request(make_req(ACT_BLEND, 255, 255, 32'hFFFF_FFFF, 1, 32'hFF00_FF00), 1'b0);
      send_request(make_req(ACT_BLEND, 255, 255, 32'h01FF_FFFF, 1, 32'hFFFF_FFFF), 1'b0);
      send_request(make_req(ACT_BLEND, 255, 0,   32'hFE12_3456, 1, 32'hFFFF_FFFF), 1'b0);
      send_request(make_req(ACT_BLEND, 0,   255, 32'h0,         0, 32'h7FAB_CDEF), 1'b0);
      send_request(make_req(ACT_READ,  255, 255, 32'h0,         0, 32'h0), 1'b0);
      send_request(make_req(ACT_READ,  0,   0,   32'h0,         0, 32'h0), 1'b0);
      send_request(make_req(ACT_NONE,  17,  33,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF), 1'b0);
      // back-to-back hits on one pixel
      send_request(make_req(ACT_BLEND, 5,   7,   32'h0,         0, 32'hFF40_80C0), 1'b1);
      send_request(make_req(ACT_BLEND, 5,   7,   32'h0,         0, 32'h8011_2233), 1'b1);
      send_request(make_req(ACT_BLEND, 5,   7,   32'hC0FF_FFFF, 1, 32'h60A0_B0C0), 1'b1);
      send_request(make_req(ACT_BLEND, 5,   7,   32'h0,         0, 32'h00FF_FFFF), 1'b1);
      send_request(make_req(ACT_READ,  5,   7,   32'h0,         0, 32'h0), 1'b1);
      send_request(make_req(ACT_CLEAR, 0,   0,   32'h0,         0, 32'h0), 1'b0);
      send_request(make_req(ACT_READ,  5,   7,   32'h0,         0, 32'h0), 1'b0);
      drain();

      write_config(1, 1, 0, 0, 256, 256);
      send_request(make_req(ACT_BLEND, 0, 0, 32'h0, 0, 32'hFF12_3456), 1'b0);
      send_request(make_req(ACT_BLEND, 1, 0, 32'h0, 0, 32'hFF12_3456), 1'b0);
      send_request(make_req(ACT_READ,  0, 1, 32'h0, 0, 32'h0), 1'b0);
      drain();

      write_config(256, 256, 256, 256, 256, 256);
      send_request(make_req(ACT_BLEND, 255, 255, 32'h0, 0, 32'hFFFF_FFFF), 1'b0);
      send_request(make_req(ACT_READ,  255, 255, 32'h0, 0, 32'h0), 1'b0);
      random_phase(100);

      write_config(256, 256, 0, 0, 256, 256);
      random_phase(240);
      random_config();
      random_phase(240);
      write_config(1, 1, 0, 0, 256, 256);
      random_phase(100);
      write_config(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                   9'($urandom_range(0, 4)), 9'($urandom_range(0, 4)),
                   9'($urandom_range(8, 20)), 9'($urandom_range(8, 20)));
      random_phase(240);
      e = $urandom_range(0, 256);
      write_config(256, 256, 9'(e), 0, 9'(e), 256);
      random_phase(100);
      random_config();
      random_phase(240);
      write_config(256, 256, 0, 0, 256, 256);
      random_phase(420);

      repeat (10) @(posedge clock);
      sb.finish_check();
      $display("Covered %0d requests over %0d register settings: %0d written, %0d skipped",
               requests, settings, sb.written, sb.skipped);
      $display("%0d clipped, %0d reads, %0d clears, %0d unused codes, random gaps both sides",
               sb.clipped, sb.reads, sb.clears, sb.unused);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
